>>> hdl/abif_pkg.sv
// ----------------------------------------------------------------------------
// abif_pkg
// Shared types and constants for the array binary search tree block:
// tree geometry, command and result payloads, status codes, memory port.
// ----------------------------------------------------------------------------
package abif_pkg;

    // Tree geometry: node n has children 2n and 2n+1, root is node 1
    localparam int LEVELS  = 4;
    localparam int NODES   = (1 << LEVELS) - 1;
    localparam int NODE_W  = LEVELS;
    localparam int KEY_W   = 32;

    typedef logic [NODE_W-1:0] t_node;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_FIND   = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_FULL      = 2'd1,
        ST_FOUND     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Input transfer payload
    typedef struct packed {
        t_mode                    mode;
        logic signed [KEY_W-1:0]  value;
    } t_cmd;

    // Result transfer payload
    typedef struct packed {
        t_status  status;
        t_node    node_index;
    } t_result;

    // Walker to node memory request
    typedef struct packed {
        t_node                    rd_addr;
        logic                     wr_en;
        t_node                    wr_addr;
        logic signed [KEY_W-1:0]  wr_data;
    } t_ram_req;

endpackage

>>> hdl/abif_node_ram.sv
// ----------------------------------------------------------------------------
// abif_node_ram
// Node key storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module abif_node_ram
    import abif_pkg::*;
(
    input  logic                     i_clk,
    input  t_ram_req                 i_req,
    output logic signed [KEY_W-1:0]  o_rd_data
);

    logic signed [KEY_W-1:0] r_mem [NODES:1];
    logic signed [KEY_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_req.rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/abif_walker.sv
// ----------------------------------------------------------------------------
// abif_walker
// Tree walk sequencer: holds the occupied flags, steps one level per cycle
// through the node memory, inserts at the first empty node or reports.
// ----------------------------------------------------------------------------
module abif_walker
    import abif_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  t_cmd                     i_cmd,
    input  logic signed [KEY_W-1:0]  i_rd_data,
    output t_ram_req                 o_req,
    output logic                     o_busy,
    output logic                     o_strobe,
    output t_result                  o_result
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

    t_state      r_state, n_state;
    t_cmd        r_cmd;
    t_node       r_node, n_node;
    logic [NODES:1] r_occ, n_occ;
    logic        r_strobe, n_strobe;
    t_result     r_result, n_result;

    logic        accept;
    logic        occ;
    logic        key_eq;
    logic        key_lt;
    logic        leaf;
    logic        wr_en;

    assign accept = i_start && (r_state == S_IDLE);
    assign occ    = r_occ[r_node];
    assign key_eq = (r_cmd.value == i_rd_data);
    assign key_lt = (r_cmd.value < i_rd_data);
    assign leaf   = r_node[NODE_W-1];

    // Walk control: one node compared per cycle
    always_comb begin
        n_state  = r_state;
        n_node   = r_node;
        n_occ    = r_occ;
        n_strobe = 1'b0;
        n_result = r_result;
        wr_en    = 1'b0;
        case (r_state)
            S_IDLE: begin
                n_node = t_node'(1);
                if (accept) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (!occ) begin
                    // empty node ends the walk
                    n_state             = S_IDLE;
                    n_strobe            = 1'b1;
                    n_result.node_index = '0;
                    if (r_cmd.mode == MODE_INSERT) begin
                        wr_en           = 1'b1;
                        n_occ[r_node]   = 1'b1;
                        n_result.status = ST_INSERTED;
                    end else begin
                        n_result.status = ST_NOT_FOUND;
                    end
                end else if (r_cmd.mode == MODE_FIND && key_eq) begin
                    n_state             = S_IDLE;
                    n_strobe            = 1'b1;
                    n_result.status     = ST_FOUND;
                    n_result.node_index = r_node;
                end else if (leaf) begin
                    // walk falls off below the last level
                    n_state             = S_IDLE;
                    n_strobe            = 1'b1;
                    n_result.node_index = '0;
                    n_result.status     = (r_cmd.mode == MODE_INSERT) ? ST_FULL
                                                                       : ST_NOT_FOUND;
                end else begin
                    // smaller goes left, equal or larger goes right
                    n_node = {r_node[NODE_W-2:0], ~key_lt};
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_occ    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_occ    <= n_occ;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_node   <= n_node;
        r_result <= n_result;
        if (accept) begin
            r_cmd <= i_cmd;
        end
    end

    // Memory request: read address follows the next node to compare
    always_comb begin
        o_req.rd_addr = n_node;
        o_req.wr_en   = wr_en;
        o_req.wr_addr = r_node;
        o_req.wr_data = r_cmd.value;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

>>> hdl/array_bst_insert_find.sv
// ----------------------------------------------------------------------------
// array_bst_insert_find
// Binary search tree of signed 32-bit keys in an implicit 15-node array.
// ----------------------------------------------------------------------------
// A command transfers at a rising edge with i_start high and o_busy low.
// The walk reads the root node at that edge and then compares one tree level
// per cycle against the single read port of the key memory, so an item holds
// the block while its walk visits 1 to 4 levels. The result strobe o_strobe
// is registered from the last compare and lasts one cycle. o_busy is already
// low in the strobe cycle, so the next command may transfer there. The
// receiver cannot stall; every result must be taken in its strobe cycle.
// Occupied flags all clear together at a clock edge with reset low.
// ----------------------------------------------------------------------------
module array_bst_insert_find
    import abif_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_cmd     i_cmd,
    output logic     o_busy,
    output logic     o_strobe,
    output t_result  o_result
);

    t_ram_req                 ram_req;
    logic signed [KEY_W-1:0]  rd_data;

    // Walk sequencer
    abif_walker u_walker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_cmd     (i_cmd),
        .i_rd_data (rd_data),
        .o_req     (ram_req),
        .o_busy    (o_busy),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

    // Node key memory
    abif_node_ram u_node_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

endmodule

>>> bench/abif_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abif_checker
// Watches the command and result channels of array_bst_insert_find. Each
// command transfer is walked through a private copy of the tree to predict
// its result. Each result strobe is compared field by field with the oldest
// outstanding prediction. Mismatches are counted and handed to the bench top.
// ----------------------------------------------------------------------------
module abif_checker
    import abif_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_busy,
    input  t_cmd    i_cmd,
    input  logic    i_strobe,
    input  t_result i_result,
    output int      o_fail_count,
    output int      o_pending
);

    // Shadow tree: keys and occupied flags, nodes 1..NODES
    logic signed [KEY_W-1:0] node_key  [1:NODES];
    logic                    node_used [1:NODES];
    t_result                 outstanding_results [$];
    int                      fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Walk from the root one level at a time; insert updates the shadow tree
    function automatic t_result tree_walk(input t_cmd c);
        t_result     r;
        int unsigned node;
        node         = 1;
        r.status     = (c.mode == MODE_INSERT) ? ST_FULL : ST_NOT_FOUND;
        r.node_index = '0;
        for (int lvl = 0; lvl < LEVELS && node <= NODES; lvl++) begin
            // empty node ends the walk: insert lands here, find misses
            if (!node_used[node]) begin
                if (c.mode == MODE_INSERT) begin
                    node_key[node]  = c.value;
                    node_used[node] = 1'b1;
                    r.status        = ST_INSERTED;
                end
                break;
            end
            if (c.mode == MODE_FIND && c.value == node_key[node]) begin
                r.status     = ST_FOUND;
                r.node_index = t_node'(node);
                break;
            end
            // smaller goes left, equal or larger goes right
            node = ($signed(c.value) < $signed(node_key[node])) ? 2 * node : 2 * node + 1;
        end
        return r;
    endfunction

    // Retire results first: a strobe belongs to an older command than one
    // transferring at the same edge
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int n = 1; n <= NODES; n++) begin
                node_used[n] = 1'b0;
            end
            outstanding_results.delete();
        end else begin
            if (i_strobe === 1'b1) begin
                if (outstanding_results.size() == 0) begin
                    report_mismatch("result strobe with no command outstanding");
                end else begin
                    want = outstanding_results.pop_front();
                    if (i_result.status !== want.status) begin
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  i_result.status, want.status));
                    end
                    if (i_result.node_index !== want.node_index) begin
                        report_mismatch($sformatf("node_index got %0d want %0d",
                                                  i_result.node_index, want.node_index));
                    end
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                outstanding_results.push_back(tree_walk(i_cmd));
            end
        end
        o_pending = outstanding_results.size();
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for array_bst_insert_find. A directed run covers the
// empty tree, key extremes, duplicates, a full walk and a find past the
// leaves; random inserts and finds follow, mostly of keys already sent in
// inserts or their neighbors. Checking is done by abif_checker beside the block.
// ----------------------------------------------------------------------------
module tb;
    import abif_pkg::*;

    localparam int IDLE_PCT     = 7;
    localparam int RANDOM_ITEMS = 735;
    localparam int STALL_LIMIT  = 2000;
    localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    i_start;
    t_cmd    i_cmd;
    logic    o_busy;
    logic    o_strobe;
    t_result o_result;

    int               fail_count;
    int               pending;
    int               quiet_cycles = 0;
    int               pick;
    bit               idle_on;
    logic [KEY_W-1:0] known_keys [$];

    array_bst_insert_find dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_cmd    (i_cmd),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    abif_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_cmd        (i_cmd),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog: too many cycles without any transfer ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start === 1'b1 && o_busy === 1'b0) || o_strobe === 1'b1) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // One command transfer, with an occasional random gap ahead of it
    task automatic send_cmd(input t_mode m, input logic [KEY_W-1:0] v);
        int gap;
        if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            gap = $urandom_range(1, 4);
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start     <= 1'b1;
        i_cmd.mode  <= m;
        i_cmd.value <= v;
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
        if (m == MODE_INSERT) begin
            known_keys.push_back(v);
        end
    endtask

    // Keys: full range, a small cluster around zero, extremes, or scaled
    function automatic logic [KEY_W-1:0] random_key();
        int k;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: begin
                k = $urandom_range(0, 16);
                return k - 8;
            end
            2: begin
                case ($urandom_range(0, 3))
                    0: return KEY_MIN;
                    1: return KEY_MAX;
                    2: return KEY_MIN + 1;
                    default: return KEY_MAX - 1;
                endcase
            end
            default: begin
                k = $urandom >> $urandom_range(1, 28);
                return $urandom_range(0, 1) ? -k : k;
            end
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] known_key();
        return known_keys[$urandom_range(0, known_keys.size() - 1)];
    endfunction

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cmd   = '0;
        idle_on = 1'b1;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty root, extremes, duplicates, walk past the leaves
        send_cmd(MODE_FIND,   32'd0);          // empty root
        send_cmd(MODE_INSERT, 32'd0);          // root
        send_cmd(MODE_INSERT, KEY_MIN);        // node 2
        send_cmd(MODE_INSERT, KEY_MAX);        // node 3
        send_cmd(MODE_INSERT, 32'd0);          // duplicate goes right, node 6
        send_cmd(MODE_FIND,   32'd0);          // first equal is the root
        send_cmd(MODE_FIND,   KEY_MIN);
        send_cmd(MODE_FIND,   KEY_MAX);
        send_cmd(MODE_FIND,   32'd5);          // misses at empty node 13
        send_cmd(MODE_INSERT, 32'hffff_ffff);  // node 5
        send_cmd(MODE_INSERT, KEY_MIN);        // duplicate of min, node 10
        send_cmd(MODE_INSERT, KEY_MIN);        // walks past the leaves: full
        send_cmd(MODE_FIND,   KEY_MIN + 1);    // find past the leaves
        send_cmd(MODE_FIND,   32'hffff_ffff);  // deepest found so far
        send_cmd(MODE_FIND,   32'h5555_aaaa);
        send_cmd(MODE_INSERT, 32'haaaa_5555);

        // Random: mostly finds of known keys and neighbors, some inserts
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_on = !(n >= 300 && n < 460);
            pick    = $urandom_range(0, 99);
            if (pick < 25) begin
                send_cmd(MODE_INSERT, ($urandom_range(0, 2) == 0) ? known_key() : random_key());
            end else if (pick < 65) begin
                send_cmd(MODE_FIND, known_key());
            end else if (pick < 80) begin
                send_cmd(MODE_FIND, known_key() + ($urandom_range(0, 1) ? 1 : -1));
            end else begin
                send_cmd(MODE_FIND, random_key());
            end
        end
        i_start <= 1'b0;

        // Drain outstanding results before the verdict
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> array_bst_insert_find.f
hdl/abif_pkg.sv
hdl/abif_node_ram.sv
hdl/abif_walker.sv
hdl/array_bst_insert_find.sv
bench/abif_checker.sv
bench/tb.sv
